// File: rtl/core/lecb_pkg.sv
`timescale 1ns / 1ps

package lecb_pkg;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // longest command emitted by one fetch
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned NW          = $clog2(MAX_RESULTS + 1);

  // command queue between front and back
  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);

  typedef enum logic [2:0] {
    ST_ECHO      = 3'd0,
    ST_DROP      = 3'd1,
    ST_FULL      = 3'd2,
    ST_CMD_BYTE  = 3'd3,
    ST_EMPTY_CMD = 3'd4,
    ST_NO_CMD    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_EDIT_CHK,
    ENG_FETCH_CHK
  } eng_state_t;

  // decoded transaction handed from front to back
  typedef struct packed {
    logic       fetch;
    logic [7:0] ch;
    logic       is_cr;
    logic       is_edit;
    logic       is_ctl;
  } cmd_t;

  // result as it leaves the back end
  typedef struct packed {
    status_t    status;
    logic [7:0] data;
    logic       last;
    logic       has_cmd;
  } res_t;

endpackage

// File: rtl/core/lecb_ram.sv
`timescale 1ns / 1ps

module lecb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/lecb_front.sv
`timescale 1ns / 1ps

module lecb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic          in_mode,
  input  logic [7:0]    in_rx_byte,
  output logic          cmd_valid,
  output lecb_pkg::cmd_t cmd,
  input  logic          cmd_take
);

  import lecb_pkg::*;

  cmd_t               q_r [CQ_DEPTH];
  logic [CQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CQ_AW:0]     cnt_r, cnt_nxt;
  logic               push_ok;
  logic               pop_ok;
  cmd_t               dec;

  // character classes
  always_comb begin
    dec.fetch   = in_mode;
    dec.ch      = in_rx_byte;
    dec.is_cr   = (in_rx_byte == CH_CR);
    dec.is_edit = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
    dec.is_ctl  = (in_rx_byte != CH_CR) && (in_rx_byte != CH_BS) &&
                  ((in_rx_byte < CH_SPACE) || (in_rx_byte > CH_DEL));
  end

  assign in_full   = (cnt_r == (CQ_AW+1)'(CQ_DEPTH));
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign pop_ok    = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (CQ_AW+1)'(push_ok) - (CQ_AW+1)'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/core/lecb_back.sv
`timescale 1ns / 1ps

module lecb_back #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  lecb_pkg::cmd_t                cmd,
  output logic                          cmd_take,
  output logic                          ram_wr_en,
  output logic [$clog2(RING_DEPTH)-1:0] ram_wr_addr,
  output logic [7:0]                    ram_wr_data,
  output logic                          ram_rd_en,
  output logic [$clog2(RING_DEPTH)-1:0] ram_rd_addr,
  input  logic [7:0]                    ram_rd_data,
  output logic                          res_valid,
  output lecb_pkg::res_t                res,
  input  logic                          res_pop
);

  import lecb_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);
  localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    ptr_dec = (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  eng_state_t    state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] scan_r, scan_nxt;
  logic [PW-1:0] cr_cnt_r, cr_cnt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [7:0]    pend_r, pend_nxt;
  logic          pend_v_r, pend_v_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          ov_r, ov_nxt;
  res_t          ores_r, ores_nxt;

  logic          out_free;
  logic          hc_now;
  logic          ring_full;
  logic          last_slot;
  logic          rd_is_cr;
  logic          need_emit;
  logic          hc_fetch;

  assign out_free  = !ov_r || res_pop;
  assign hc_now    = (cr_cnt_r != '0);
  assign hc_fetch  = (cr_cnt_r > PW'(1));
  assign ring_full = (ptr_inc(wp_r) == rp_r);
  assign last_slot = (ptr_inc(ptr_inc(wp_r)) == rp_r);
  assign rd_is_cr  = (ram_rd_data == CH_CR);
  assign need_emit = (n_r < NW'(MAX_RESULTS));

  assign res_valid = ov_r;
  assign res       = ores_r;

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    scan_nxt    = scan_r;
    cr_cnt_nxt  = cr_cnt_r;
    n_nxt       = n_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    ch_nxt      = ch_r;
    ov_nxt      = ov_r && !res_pop;
    ores_nxt    = ores_r;
    cmd_take    = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = wp_r;
    ram_wr_data = cmd.ch;
    ram_rd_en   = 1'b0;
    ram_rd_addr = rp_r;

    case (state_r)
      ENG_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take = 1'b1;
          if (cmd.fetch) begin
            if (!hc_now) begin
              ov_nxt   = 1'b1;
              ores_nxt = '{status: ST_NO_CMD, data: 8'h00, last: 1'b1, has_cmd: 1'b0};
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = rp_r;
              scan_nxt    = rp_r;
              pend_v_nxt  = 1'b0;
              n_nxt       = '0;
              state_nxt   = ENG_FETCH_CHK;
            end
          end else if (ring_full) begin
            ov_nxt   = 1'b1;
            ores_nxt = '{status: ST_FULL, data: 8'h00, last: 1'b1, has_cmd: hc_now};
          end else if (cmd.is_ctl || (last_slot && !cmd.is_cr && !cmd.is_edit)) begin
            ov_nxt   = 1'b1;
            ores_nxt = '{status: ST_DROP, data: 8'h00, last: 1'b1, has_cmd: hc_now};
          end else if (cmd.is_edit) begin
            if (wp_r != rp_r) begin
              // need the newest byte to know whether a CR goes away
              ram_rd_en   = 1'b1;
              ram_rd_addr = ptr_dec(wp_r);
              ch_nxt      = cmd.ch;
              state_nxt   = ENG_EDIT_CHK;
            end else begin
              ov_nxt   = 1'b1;
              ores_nxt = '{status: ST_ECHO, data: cmd.ch, last: 1'b1, has_cmd: hc_now};
            end
          end else begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wp_r;
            ram_wr_data = cmd.ch;
            wp_nxt      = ptr_inc(wp_r);
            cr_cnt_nxt  = cr_cnt_r + PW'(cmd.is_cr);
            ov_nxt      = 1'b1;
            ores_nxt    = '{status: ST_ECHO, data: cmd.ch, last: 1'b1,
                            has_cmd: hc_now || cmd.is_cr};
          end
        end
      end

      ENG_EDIT_CHK: begin
        if (out_free) begin
          cr_cnt_nxt = cr_cnt_r - PW'(rd_is_cr);
          wp_nxt     = ptr_dec(wp_r);
          ov_nxt     = 1'b1;
          ores_nxt   = '{status: ST_ECHO, data: ch_r, last: 1'b1,
                         has_cmd: (cr_cnt_r - PW'(rd_is_cr)) != '0};
          state_nxt  = ENG_IDLE;
        end
      end

      ENG_FETCH_CHK: begin
        // ram_rd_data holds the byte at scan_r; pend_r the byte before it
        if (!pend_v_r) begin
          if (rd_is_cr) begin
            if (out_free) begin
              ov_nxt     = 1'b1;
              ores_nxt   = '{status: ST_EMPTY_CMD, data: 8'h00, last: 1'b1,
                             has_cmd: hc_fetch};
              rp_nxt     = ptr_inc(scan_r);
              cr_cnt_nxt = cr_cnt_r - PW'(1);
              state_nxt  = ENG_IDLE;
            end
          end else begin
            pend_nxt    = ram_rd_data;
            pend_v_nxt  = 1'b1;
            scan_nxt    = ptr_inc(scan_r);
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_inc(scan_r);
          end
        end else if (!need_emit || out_free) begin
          if (need_emit) begin
            ov_nxt   = 1'b1;
            ores_nxt = '{status: ST_CMD_BYTE, data: pend_r,
                         last: rd_is_cr || (n_r == NW'(MAX_RESULTS - 1)),
                         has_cmd: hc_fetch};
            n_nxt    = n_r + 1'b1;
          end
          if (rd_is_cr) begin
            rp_nxt     = ptr_inc(scan_r);
            cr_cnt_nxt = cr_cnt_r - PW'(1);
            pend_v_nxt = 1'b0;
            state_nxt  = ENG_IDLE;
          end else begin
            pend_nxt    = ram_rd_data;
            scan_nxt    = ptr_inc(scan_r);
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_inc(scan_r);
          end
        end
      end

      default: begin
        state_nxt = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ENG_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      cr_cnt_r <= '0;
      pend_v_r <= 1'b0;
      n_r      <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      cr_cnt_r <= cr_cnt_nxt;
      pend_v_r <= pend_v_nxt;
      n_r      <= n_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    pend_r <= pend_nxt;
    ch_r   <= ch_nxt;
    ores_r <= ores_nxt;
  end

endmodule

// File: rtl/core/line_edit_command_buffer_unit.sv
`timescale 1ns / 1ps
// A received byte passes through the two-entry command queue and the back end's result
// register; BS/DEL on a non-empty ring first reads the newest stored byte back from the ring RAM.
// Throughput: one received byte per cycle into a two-entry queue while it is not full, drained
// at up to one per cycle; a fetch reads the ring one byte per cycle through the RAM read port.
// Output stalls hold the engine.
// Reset (rst_n low, synchronous) empties the ring pointers and queues; ring RAM is not cleared.

module line_edit_command_buffer_unit #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_mode,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [2:0] out_status,
  output logic [7:0] out_data_byte,
  output logic       out_last,
  output logic       out_has_command
);

  import lecb_pkg::*;

  localparam int unsigned PW = $clog2(RING_DEPTH);

  cmd_t          cmd;
  logic          cmd_valid;
  logic          cmd_take;
  logic          ram_wr_en;
  logic [PW-1:0] ram_wr_addr;
  logic [7:0]    ram_wr_data;
  logic          ram_rd_en;
  logic [PW-1:0] ram_rd_addr;
  logic [7:0]    ram_rd_data;
  logic          res_valid;
  res_t          res;

  lecb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_take   (cmd_take)
  );

  lecb_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lecb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_pop     (out_pop)
  );

  assign out_empty       = !res_valid;
  assign out_status      = res.status;
  assign out_data_byte   = res.data;
  assign out_last        = res.last;
  assign out_has_command = res.has_cmd;

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lecb_pkg::*;

  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned TAIL_WAIT  = 20;
  localparam int unsigned RANDOM_ITEMS = 360;

  typedef logic [PTR_W-1:0] ptr_t;

  // Keeps its own copy of the edit ring and queues the results each transaction causes
  class line_edit_scoreboard;
    logic [7:0]  line_ring [RING_DEPTH];
    ptr_t        wr_ptr;
    ptr_t        rd_ptr;
    res_t        expected_results [$];
    int unsigned mismatches;

    function new();
      wr_ptr     = '0;
      rd_ptr     = '0;
      mismatches = 0;
    endfunction

    function bit ring_holds_cr();
      ptr_t p;
      p = rd_ptr;
      while (p != wr_ptr) begin
        if (line_ring[p] == CH_CR) return 1'b1;
        p = ptr_t'(p + 1);
      end
      return 1'b0;
    endfunction

    function res_t make_result(status_t st, logic [7:0] d);
      res_t r;
      r.status  = st;
      r.data    = d;
      r.last    = 1'b0;
      r.has_cmd = 1'b0;
      return r;
    endfunction

    function void note_keystroke(logic mode, logic [7:0] ch);
      res_t step_q [$];
      res_t r;
      logic is_edit;
      logic cr_left;
      is_edit = (ch == CH_BS) || (ch == CH_DEL);
      if (!mode) begin
        if (ptr_t'(wr_ptr + 1) == rd_ptr) begin
          step_q.push_back(make_result(ST_FULL, 8'h00));
        end else if (ch != CH_CR && ch != CH_BS && (ch < CH_SPACE || ch > CH_DEL)) begin
          step_q.push_back(make_result(ST_DROP, 8'h00));
        end else if (ptr_t'(wr_ptr + 2) == rd_ptr && ch != CH_CR && !is_edit) begin
          // last free slot is kept for the terminating CR
          step_q.push_back(make_result(ST_DROP, 8'h00));
        end else begin
          if (is_edit) begin
            if (wr_ptr != rd_ptr) wr_ptr = ptr_t'(wr_ptr - 1);
          end else begin
            line_ring[wr_ptr] = ch;
            wr_ptr = ptr_t'(wr_ptr + 1);
          end
          step_q.push_back(make_result(ST_ECHO, ch));
        end
      end else if (!ring_holds_cr()) begin
        step_q.push_back(make_result(ST_NO_CMD, 8'h00));
      end else begin
        while (line_ring[rd_ptr] != CH_CR) begin
          if (step_q.size() < MAX_RESULTS)
            step_q.push_back(make_result(ST_CMD_BYTE, line_ring[rd_ptr]));
          rd_ptr = ptr_t'(rd_ptr + 1);
        end
        rd_ptr = ptr_t'(rd_ptr + 1);
        if (step_q.size() == 0) step_q.push_back(make_result(ST_EMPTY_CMD, 8'h00));
      end
      cr_left = ring_holds_cr();
      foreach (step_q[i]) begin
        r         = step_q[i];
        r.has_cmd = cr_left;
        r.last    = (i == step_q.size() - 1);
        expected_results.push_back(r);
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 20) $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d data=%02h",
                                  got.status, got.data));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.data !== want.data)
          report_mismatch($sformatf("data_byte got %02h want %02h", got.data, want.data));
        if (got.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", got.last, want.last));
        if (got.has_cmd !== want.has_cmd)
          report_mismatch($sformatf("has_command got %b want %b", got.has_cmd, want.has_cmd));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n      = 1'b0;
  logic       in_push    = 1'b0;
  logic       in_mode    = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_pop    = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic [2:0] out_status;
  logic [7:0] out_data_byte;
  logic       out_last;
  logic       out_has_command;

  line_edit_scoreboard sb = new();

  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;

  line_edit_command_buffer_unit #(
    .RING_DEPTH(RING_DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_rx_byte     (in_rx_byte),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last),
    .out_has_command(out_has_command)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) sb.note_keystroke(in_mode, in_rx_byte);
  end

  always @(posedge clk) begin : result_monitor
    res_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.status  = status_t'(out_status);
      got.data    = out_data_byte;
      got.last    = out_last;
      got.has_cmd = out_has_command;
      sb.check_result(got);
    end
  end

  // Receiver: random 16-bit pop patterns with slot 0 always set, plus long holds the stimulus requests
  initial begin : drain_side
    logic [15:0] pop_pattern;
    int unsigned slot;
    pop_pattern = '1;
    slot        = 0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end
      if (slot == 0) begin
        case ($urandom_range(0, 3))
          0:       pop_pattern = '1;
          1:       pop_pattern = 16'($urandom) | 16'h0001;
          2:       pop_pattern = 16'($urandom & $urandom) | 16'h0001;
          default: pop_pattern = 16'($urandom | $urandom) | 16'h0001;
        endcase
      end
      out_pop <= pop_pattern[slot];
      slot = (slot + 1) % 16;
    end
  end

  // One transaction, sent in bursts with random gaps between them
  task automatic offer_keystroke(input logic mode, input logic [7:0] ch);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_push    <= 1'b1;
    in_mode    <= mode;
    in_rx_byte <= ch;
    do @(posedge clk); while (in_full);
    items_sent++;
  endtask

  task automatic wait_until_drained();
    in_push <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned next_hold_at;
    int unsigned cmd_len;
    int unsigned k;
    bit          paused;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fetch on empty ring, edits on empty ring, control/high drops
    offer_keystroke(1'b1, 8'hff);
    offer_keystroke(1'b0, CH_BS);
    offer_keystroke(1'b0, CH_DEL);
    offer_keystroke(1'b0, 8'h00);
    offer_keystroke(1'b0, 8'h1f);
    offer_keystroke(1'b0, 8'h80);
    offer_keystroke(1'b0, 8'hff);
    // bare CR gives an empty command
    offer_keystroke(1'b0, CH_CR);
    offer_keystroke(1'b1, 8'h00);
    offer_keystroke(1'b0, CH_SPACE);
    offer_keystroke(1'b0, 8'h7e);
    offer_keystroke(1'b0, 8'h61);
    offer_keystroke(1'b0, CH_BS);
    offer_keystroke(1'b0, 8'h41);
    offer_keystroke(1'b0, CH_CR);
    offer_keystroke(1'b0, 8'h78);
    offer_keystroke(1'b0, CH_CR);
    // backspace eats a stored CR
    offer_keystroke(1'b0, CH_BS);
    offer_keystroke(1'b0, CH_DEL);
    offer_keystroke(1'b1, 8'h55);
    offer_keystroke(1'b1, 8'haa);
    offer_keystroke(1'b0, 8'h7a);
    offer_keystroke(1'b0, CH_CR);
    offer_keystroke(1'b0, 8'h71);
    offer_keystroke(1'b1, 8'h01);
    offer_keystroke(1'b1, 8'h80);
    wait_until_drained();

    base         = items_sent;
    next_hold_at = 100;
    paused       = 1'b0;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (hold_requests < 2 && items_sent - base >= next_hold_at) begin
        hold_requests++;
        next_hold_at += 150;
      end
      if (!paused && items_sent - base >= 180) begin
        wait_until_drained();
        paused = 1'b1;
      end
      case ($urandom_range(0, 99)) inside
        [0:54]: begin
          cmd_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 29) : $urandom_range(0, 8);
          for (k = 0; k < cmd_len; k++) begin
            if ($urandom_range(0, 9) == 0)
              offer_keystroke(1'b0, $urandom_range(0, 1) ? CH_BS : CH_DEL);
            else
              offer_keystroke(1'b0, 8'($urandom_range(32, 126)));
          end
          offer_keystroke(1'b0, CH_CR);
          if ($urandom_range(0, 9) < 7) offer_keystroke(1'b1, 8'($urandom));
        end
        [55:64]: begin
          // overrun the ring: last-slot drops, then refusals once full
          cmd_len = $urandom_range(30, 34);
          for (k = 0; k < cmd_len; k++) offer_keystroke(1'b0, 8'($urandom_range(32, 126)));
          offer_keystroke(1'b0, CH_CR);
          offer_keystroke(1'b0, 8'($urandom));
          offer_keystroke(1'b0, 8'($urandom));
          repeat ($urandom_range(1, 4)) offer_keystroke(1'b1, 8'($urandom));
        end
        [65:74]: begin
          // unterminated line then a fetch
          cmd_len = $urandom_range(1, 6);
          for (k = 0; k < cmd_len; k++) offer_keystroke(1'b0, 8'($urandom_range(32, 126)));
          offer_keystroke(1'b1, 8'($urandom));
        end
        [75:92]: offer_keystroke(1'($urandom), 8'($urandom));
        default: repeat ($urandom_range(1, 3)) offer_keystroke(1'b1, 8'($urandom));
      endcase
    end

    wait_until_drained();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd10_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
